// ----- rtl/core/rbb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rbb_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MAX_RADIUS_DEF = 3;

  localparam int CFG_W     = 11;
  localparam int RAD_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CHAN_W    = 8;
  localparam int PIX_W     = 3 * CHAN_W;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd1024;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd1024;
  localparam logic [RAD_W-1:0] RADIUS_RST = 2'd1;

  // quotient = (sum * recip) >> RECIP_K, exact for every window sum up to 225 * 255
  localparam int RECIP_K = 24;
  localparam int RECIP_W = 25;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_BLUR_RADIUS  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic              mode;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              frame_end;
  } out_item_t;

  typedef struct packed {
    logic clr;
    logic acc;
    logic mul;
  } lane_ctrl_t;

  // ceil(2^24 / (2r+1)^2) for radius 0..7
  function automatic logic [RECIP_W-1:0] recip_mult(input logic [2:0] rad);
    logic [RECIP_W-1:0] m;
    begin
      case (rad)
        3'd0: m = 25'd16777216;
        3'd1: m = 25'd1864136;
        3'd2: m = 25'd671089;
        3'd3: m = 25'd342393;
        3'd4: m = 25'd207127;
        3'd5: m = 25'd138655;
        3'd6: m = 25'd99274;
        3'd7: m = 25'd74566;
        default: m = 25'd16777216;
      endcase
      return m;
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rbb_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rbb_lane #(
  parameter int SUM_W = 16
) (
  input  wire logic                        clk,
  input  wire rbb_pkg::lane_ctrl_t         ctrl,
  input  wire logic [rbb_pkg::CHAN_W-1:0]  din,
  input  wire logic [rbb_pkg::RECIP_W-1:0] recip,
  output logic      [rbb_pkg::CHAN_W-1:0]  quot
);
  import rbb_pkg::*;

  logic [SUM_W-1:0]         sum_r;
  logic [SUM_W+RECIP_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      sum_r <= '0;
    end else if (ctrl.acc) begin
      sum_r <= sum_r + SUM_W'(din);
    end
    if (ctrl.mul) begin
      prod_r <= (SUM_W+RECIP_W)'(sum_r) * (SUM_W+RECIP_W)'(recip);
    end
  end

  assign quot = prod_r[RECIP_K +: CHAN_W];

endmodule

`default_nettype wire

// ----- rtl/core/rbb_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rbb_merge (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       load,
  input  wire logic [rbb_pkg::CHAN_W-1:0] red_q,
  input  wire logic [rbb_pkg::CHAN_W-1:0] green_q,
  input  wire logic [rbb_pkg::CHAN_W-1:0] blue_q,
  input  wire logic                       frame_end,
  input  wire logic                       out_ready,
  output logic                            out_valid,
  output rbb_pkg::out_item_t              out_data,
  output logic                            out_free
);
  import rbb_pkg::*;

  logic      out_valid_r;
  out_item_t out_data_r;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= '{red_out: red_q, green_out: green_q, blue_out: blue_q,
                      frame_end: frame_end};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/core/rgb_box_blur.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | handshake            | payload
// in_     | in  | in_valid / in_ready  | in_data   (mode, red_in, green_in, blue_in)
// out_    | out | out_valid / out_ready| out_data  (red_out, green_out, blue_out, frame_end)
// cfg_    | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// a pixel that yields no result leaves in_ready high; one that yields a result has its
// (2r+1)^2 window read through the single read port of the line store (one window
// pixel per cycle), with border pixels read once
// synchronous active-low reset; the line store is not cleared
// in_ready is low after a result's beat until that result is loaded into the output
// register, and that load waits while the previous result still sits unaccepted there

module rgb_box_blur #(
  parameter int MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rbb_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = rbb_pkg::MAX_RADIUS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire rbb_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output rbb_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rbb_pkg::CFG_W-1:0]     cfg_data
);
  import rbb_pkg::*;

  localparam int ROWS  = 2 * MAX_RADIUS + 2;
  localparam int COLW  = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int SW    = $clog2(ROWS);
  localparam int DEPTH = ROWS * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int DW    = $clog2(2 * MAX_RADIUS + 1);
  localparam int SUM_W = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) * 255 + 1);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_WAIT, S_MUL, S_DONE} state_t;

  state_t             st_r, st_nxt;
  logic [CFG_W-1:0]   width_r, width_nxt, height_r, height_nxt;
  logic [RAD_W-1:0]   radius_r, radius_nxt;
  logic [COLW-1:0]    in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [HW-1:0]      in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [SW-1:0]      in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;
  logic [PW-1:0]      pend_r, pend_nxt;
  logic [SW-1:0]      rd_slot_r, rd_slot_nxt;
  logic [COLW-1:0]    col_base_r, col_base_nxt;
  logic [DW-1:0]      dx_r, dx_nxt, dy_r, dy_nxt, span_r, span_nxt;
  logic               fend_r, fend_nxt;
  logic [RECIP_W-1:0] recip_r, recip_nxt;
  logic               rd_vld_r;
  logic [PIX_W-1:0]   rd_data_r;
  logic [PIX_W-1:0]   mem [DEPTH];

  logic [WW-1:0]   eff_w;
  logic [HW-1:0]   eff_h;
  logic [RW-1:0]   eff_r;
  logic [PW-1:0]   delay;
  logic [PW-1:0]   pend_inc;
  logic [WW-1:0]   in_col_inc, out_col_inc;
  logic [HW-1:0]   out_row_inc;
  logic            in_acc, input_done, pix_go, start_out, interior, out_free, load;
  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  lane_ctrl_t      lctl;
  logic [CHAN_W-1:0] quot [3];

  always_comb begin
    if (width_r == '0) eff_w = WW'(1);
    else if (int'(width_r) > MAX_WIDTH) eff_w = WW'(MAX_WIDTH);
    else eff_w = WW'(width_r);
    if (height_r == '0) eff_h = HW'(1);
    else if (int'(height_r) > MAX_HEIGHT) eff_h = HW'(MAX_HEIGHT);
    else eff_h = HW'(height_r);
    if (int'(radius_r) > MAX_RADIUS) eff_r = RW'(MAX_RADIUS);
    else eff_r = RW'(radius_r);
  end

  assign delay       = PW'(eff_r) * PW'(eff_w) + PW'(eff_r);
  assign in_ready    = (st_r == S_IDLE);
  assign cfg_ready   = 1'b1;
  assign in_acc      = in_valid && in_ready;
  assign input_done  = (in_row_r >= eff_h);
  assign pix_go      = in_acc && !in_data.mode && !input_done;
  assign pend_inc    = pend_r + PW'(1);
  assign in_col_inc  = WW'(in_col_r) + WW'(1);
  assign out_col_inc = WW'(out_col_r) + WW'(1);
  assign out_row_inc = out_row_r + HW'(1);
  assign start_out   = in_acc && (pix_go ? (pend_inc > delay) : input_done);
  assign interior    = (out_row_r >= HW'(eff_r))
                    && ((HW+1)'(out_row_r) + (HW+1)'(eff_r) < (HW+1)'(eff_h))
                    && (WW'(out_col_r) >= WW'(eff_r))
                    && ((WW+1)'(out_col_r) + (WW+1)'(eff_r) < (WW+1)'(eff_w));
  assign we    = pix_go;
  assign re    = (st_r == S_READ);
  assign waddr = AW'(in_slot_r) * AW'(MAX_WIDTH) + AW'(in_col_r);
  assign raddr = AW'(rd_slot_r) * AW'(MAX_WIDTH) + AW'(col_base_r) + AW'(dx_r);
  assign load  = (st_r == S_DONE) && out_free;

  always_comb begin
    st_nxt       = st_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    radius_nxt   = radius_r;
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    in_slot_nxt  = in_slot_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_slot_nxt = out_slot_r;
    pend_nxt     = pend_r;
    rd_slot_nxt  = rd_slot_r;
    col_base_nxt = col_base_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    span_nxt     = span_r;
    fend_nxt     = fend_r;
    recip_nxt    = recip_r;

    case (st_r)
      S_IDLE: begin
        if (pix_go) begin
          pend_nxt = pend_inc;
          if (in_col_inc >= eff_w) begin
            in_col_nxt  = '0;
            in_row_nxt  = in_row_r + HW'(1);
            in_slot_nxt = (int'(in_slot_r) == ROWS - 1) ? '0 : in_slot_r + SW'(1);
          end else begin
            in_col_nxt = COLW'(in_col_inc);
          end
        end
        if (start_out) begin
          st_nxt = S_READ;
          dx_nxt = '0;
          dy_nxt = '0;
          if (interior) begin
            span_nxt     = DW'({eff_r, 1'b0});
            col_base_nxt = out_col_r - COLW'(eff_r);
            recip_nxt    = recip_mult(3'(eff_r));
            if (out_slot_r >= SW'(eff_r)) rd_slot_nxt = out_slot_r - SW'(eff_r);
            else rd_slot_nxt = SW'((SW+1)'(out_slot_r) + (SW+1)'(ROWS) - (SW+1)'(eff_r));
          end else begin
            span_nxt     = '0;
            col_base_nxt = out_col_r;
            recip_nxt    = recip_mult(3'd0);
            rd_slot_nxt  = out_slot_r;
          end
          // advance the output position; the last pixel closes the frame
          fend_nxt = 1'b0;
          pend_nxt = (pix_go ? pend_inc : pend_r) - PW'(1);
          if (out_col_inc >= eff_w) begin
            out_col_nxt  = '0;
            out_row_nxt  = out_row_inc;
            out_slot_nxt = (int'(out_slot_r) == ROWS - 1) ? '0 : out_slot_r + SW'(1);
            if (out_row_inc >= eff_h) begin
              fend_nxt     = 1'b1;
              in_col_nxt   = '0;
              in_row_nxt   = '0;
              in_slot_nxt  = '0;
              out_row_nxt  = '0;
              out_slot_nxt = '0;
              pend_nxt     = '0;
            end
          end else begin
            out_col_nxt = COLW'(out_col_inc);
          end
        end
      end
      S_READ: begin
        if (dx_r == span_r) begin
          dx_nxt = '0;
          if (dy_r == span_r) begin
            st_nxt = S_WAIT;
          end else begin
            dy_nxt      = dy_r + DW'(1);
            rd_slot_nxt = (int'(rd_slot_r) == ROWS - 1) ? '0 : rd_slot_r + SW'(1);
          end
        end else begin
          dx_nxt = dx_r + DW'(1);
        end
      end
      S_WAIT: st_nxt = S_MUL;
      S_MUL:  st_nxt = S_DONE;
      S_DONE: begin
        if (out_free) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  width_nxt  = cfg_data;
        REG_FRAME_HEIGHT: height_nxt = cfg_data;
        REG_BLUR_RADIUS:  radius_nxt = cfg_data[RAD_W-1:0];
        default: ;
      endcase
      if (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT ||
          cfg_index == REG_BLUR_RADIUS) begin
        in_col_nxt   = '0;
        in_row_nxt   = '0;
        in_slot_nxt  = '0;
        out_col_nxt  = '0;
        out_row_nxt  = '0;
        out_slot_nxt = '0;
        pend_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      width_r    <= WIDTH_RST;
      height_r   <= HEIGHT_RST;
      radius_r   <= RADIUS_RST;
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_slot_r  <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_slot_r <= '0;
      pend_r     <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      radius_r   <= radius_nxt;
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      in_slot_r  <= in_slot_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      out_slot_r <= out_slot_nxt;
      pend_r     <= pend_nxt;
      rd_vld_r   <= re;
    end
    rd_slot_r  <= rd_slot_nxt;
    col_base_r <= col_base_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    span_r     <= span_nxt;
    fend_r     <= fend_nxt;
    recip_r    <= recip_nxt;
  end

  // line store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {in_data.red_in, in_data.green_in, in_data.blue_in};
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign lctl = '{clr: start_out, acc: rd_vld_r, mul: (st_r == S_MUL)};

  for (genvar i = 0; i < 3; i++) begin : g_lane
    rbb_lane #(.SUM_W(SUM_W)) u_lane (
      .clk  (clk),
      .ctrl (lctl),
      .din  (rd_data_r[(2 - i) * CHAN_W +: CHAN_W]),
      .recip(recip_r),
      .quot (quot[i])
    );
  end

  rbb_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .red_q    (quot[0]),
    .green_q  (quot[1]),
    .blue_q   (quot[2]),
    .frame_end(fend_r),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data),
    .out_free (out_free)
  );

endmodule

`default_nettype wire

// ----- rtl/core/rbb_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rbb_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire rbb_pkg::out_item_t out_data
);
  import rbb_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // results never show up in the cycle right after an input beat
  a_no_fast_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result appeared too early");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind rgb_box_blur rbb_chk u_rbb_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

`default_nettype wire
